>>> src/quadratic_probe_hash_insert_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic probing hash insert block
// Shared helpers so that every checked property reads the same way.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_INSERT_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while in reset.
`define QPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and ignored while in reset.
`define QPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg
// Types and constants shared by the hash insert block and its modulo unit.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int MOD_W       = SLOT_W + 1;
    localparam int HASH_W      = 64;
    localparam int CNT_W       = $clog2(HASH_W);
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1021);
    localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(TABLE_SLOTS);

    typedef struct packed {
        logic [7:0] key_char;
        logic       key_last;
    } key_req_t;

    typedef struct packed {
        logic [9:0] slot_index;
        logic       placed;
    } slot_res_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [MOD_W-1:0]  modulus;
    } qph_div_ctl_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } qph_div_sts_t;

endpackage

>>> src/qph_modulo.sv
// ----------------------------------------------------------------------------
// qph_modulo
// Bit-serial remainder of a 64-bit hash by the table modulus, one bit a cycle.
// ----------------------------------------------------------------------------
module qph_modulo
    import qph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qph_div_ctl_t ctl,
    output qph_div_sts_t sts
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] val_reg, val_next;
    logic [MOD_W-1:0]  mod_reg, mod_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [MOD_W-1:0]  trial;

    // The partial remainder stays below the modulus, so one subtract suffices.
    always_comb
    begin
        trial     = {rem_reg, val_reg[HASH_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        mod_next  = mod_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            if (trial >= mod_reg)
            begin
                trial = trial - mod_reg;
            end
            rem_next = trial[SLOT_W-1:0];
            val_next = {val_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = ctl.dividend;
            mod_next  = ctl.modulus;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        mod_reg <= mod_next;
        rem_reg <= rem_next;
    end

    assign sts.done = done_reg;
    assign sts.rem  = rem_reg;

endmodule

>>> src/quadratic_probe_hash_insert.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_insert
// Hash table insert with quadratic probing over a 1024-slot occupancy bitmap.
// ----------------------------------------------------------------------------
// Key characters are taken one per cycle while key_stall is low and folded
// into a 64-bit running hash (h = h*37 + char, wrapping). A character request
// that is not flagged last gives no result. The last character starts the
// insert: a bit-serial modulo unit reduces the hash by the table modulus, then
// every probe forms the slot address and reads the bitmap memory in ST_ADDR
// and tests the bit in ST_CHECK, for up to modulus+1 probes. After reset the
// block clears the bitmap, one slot per cycle, and holds key_stall high during
// that pass; the table modulus register may be written meanwhile. Software
// must write a prime modulus between 2 and 1024; zero acts as 1 and larger
// values act as 1024.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_insert_defines.svh"

module quadratic_probe_hash_insert
    import qph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Key character channel.
    input  logic        key_valid,
    output logic        key_stall,
    input  key_req_t    key_data,
    // Result channel.
    output logic        slot_valid,
    input  logic        slot_stall,
    output slot_res_t   slot_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [MOD_W-1:0]  mod_reg;
    logic [MOD_W-1:0]  mod_eff;
    logic [HASH_W-1:0] hash_reg, hash_next, hash_new;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [SLOT_W-1:0] sq_reg, sq_next;
    logic [SLOT_W-1:0] d_reg, d_next;
    logic [MOD_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic              minus_reg, minus_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_calc;
    logic              rd_reg;
    logic              out_valid_reg, out_valid_next;
    slot_res_t         out_reg, out_next;
    logic              key_accept;
    logic              out_free;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [MOD_W-1:0]  sum_w;
    logic [MOD_W-1:0]  diff_w;
    logic [MOD_W-1:0]  sq_sum;
    logic [MOD_W-1:0]  d_sum;
    logic              occ_mem [TABLE_SLOTS];
    qph_div_ctl_t      div_ctl;
    qph_div_sts_t      div_sts;

    // ------------------------------------------------------------------
    // Configuration register. Only word 0 exists; other words read zero.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - MOD_W){1'b0}}, mod_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MOD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            mod_reg <= pwdata[MOD_W-1:0];
        end
    end

    // A zero modulus behaves as one, and anything past the table as its size.
    always_comb
    begin
        if (mod_reg == '0)
        begin
            mod_eff = MOD_W'(1);
        end
        else if (mod_reg > MOD_MAX)
        begin
            mod_eff = MOD_MAX;
        end
        else
        begin
            mod_eff = mod_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    assign key_stall  = (state_reg != ST_IDLE);
    assign key_accept = key_valid && !key_stall;
    assign out_free   = !out_valid_reg || !slot_stall;
    assign slot_valid = out_valid_reg;
    assign slot_data  = out_reg;

    // Multiply by 37 written as shifts and adds: 32 + 4 + 1.
    assign hash_new = (hash_reg << 5) + (hash_reg << 2) + hash_reg
                      + {{(HASH_W - 8){1'b0}}, key_data.key_char};

    assign div_ctl.start    = key_accept && key_data.key_last;
    assign div_ctl.dividend = hash_new;
    assign div_ctl.modulus  = mod_eff;

    qph_modulo u_modulo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    // ------------------------------------------------------------------
    // Probe address. The home slot comes first, then home plus the current
    // square and home minus it, all kept in the range 0..P-1.
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_w  = {1'b0, home_reg} + {1'b0, sq_reg};
        diff_w = {1'b0, home_reg} - {1'b0, sq_reg};
        if (sum_w >= mod_eff)
        begin
            sum_w = sum_w - mod_eff;
        end
        if (home_reg < sq_reg)
        begin
            diff_w = diff_w + mod_eff;
        end
        if (first_reg)
        begin
            slot_calc = home_reg;
        end
        else if (minus_reg)
        begin
            slot_calc = diff_w[SLOT_W-1:0];
        end
        else
        begin
            slot_calc = sum_w[SLOT_W-1:0];
        end
    end

    // Next square and next odd step, each reduced by a single subtract.
    always_comb
    begin
        sq_sum = {1'b0, sq_reg} + {1'b0, d_reg};
        d_sum  = {1'b0, d_reg} + MOD_W'(2);
        if (sq_sum >= mod_eff)
        begin
            sq_sum = sq_sum - mod_eff;
        end
        if (d_sum >= mod_eff)
        begin
            d_sum = d_sum - mod_eff;
        end
        if (mod_eff == MOD_W'(1))
        begin
            d_sum = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        clr_next       = clr_reg;
        home_next      = home_reg;
        sq_next        = sq_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        minus_next     = minus_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && slot_stall;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (key_accept)
                begin
                    if (key_data.key_last)
                    begin
                        hash_next  = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        hash_next = hash_new;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    home_next  = div_sts.rem;
                    first_next = 1'b1;
                    minus_next = 1'b0;
                    cnt_next   = '0;
                    // First square is 1 and the step to the next is 3, mod P.
                    sq_next    = (mod_eff == MOD_W'(1)) ? '0 : SLOT_W'(1);
                    if (mod_eff == MOD_W'(1) || mod_eff == MOD_W'(3))
                    begin
                        d_next = '0;
                    end
                    else if (mod_eff == MOD_W'(2))
                    begin
                        d_next = SLOT_W'(1);
                    end
                    else
                    begin
                        d_next = SLOT_W'(3);
                    end
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rd_reg)
                begin
                    if (out_free)
                    begin
                        mem_we              = 1'b1;
                        out_next.slot_index = slot_reg;
                        out_next.placed     = 1'b1;
                        out_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else if (cnt_reg == mod_eff)
                begin
                    if (out_free)
                    begin
                        out_next.slot_index = '0;
                        out_next.placed     = 1'b0;
                        out_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        minus_next = 1'b0;
                    end
                    else if (!minus_reg)
                    begin
                        minus_next = 1'b1;
                    end
                    else
                    begin
                        minus_next = 1'b0;
                        sq_next    = sq_sum[SLOT_W-1:0];
                        d_next     = d_sum[SLOT_W-1:0];
                    end
                    state_next = ST_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hash_reg      <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            minus_reg     <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg <= home_next;
        sq_reg   <= sq_next;
        d_reg    <= d_next;
        out_reg  <= out_next;
        if (state_reg == ST_ADDR)
        begin
            slot_reg <= slot_calc;
        end
    end

    // Occupancy bitmap: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= occ_mem[slot_calc];
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `QPH_ASSERT_NOW(a_placed_in_range, slot_valid && slot_data.placed,
        {1'b0, slot_data.slot_index} < mod_eff, "placed slot outside the modulus")
    `QPH_ASSERT_NOW(a_fail_zero_index, slot_valid && !slot_data.placed,
        slot_data.slot_index == '0, "failed insert reports a nonzero slot")
    `QPH_ASSERT_NOW(a_probe_terms_reduced, state_reg == ST_CHECK,
        ({1'b0, sq_reg} < mod_eff) && ({1'b0, d_reg} < mod_eff) && (cnt_reg <= mod_eff),
        "probe square, step or count out of range")
    `QPH_ASSERT_NEXT(a_plain_char_stays_idle, key_accept && !key_data.key_last,
        state_reg == ST_IDLE, "non-final character left the idle state")

endmodule
